/* rtl/bitmap_first_fit_block_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the block allocator
// Shared forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// implication checked while out of reset
`define BFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the next cycle
`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/bffa_pkg.sv */
// ----------------------------------------------------------------------------
// Block allocator package
// Types and constants shared by the allocator modules.
// ----------------------------------------------------------------------------
package bffa_pkg;
    localparam int MAP_BLOCKS_DEF = 4096;
    localparam int WORD_BITS      = 32;
    localparam int CNT_W          = 13;
    localparam int START_W        = 12;
    localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 13'd8191;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_MARK_FREE = 2'd2,
        CMD_MARK_USED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOSPC  = 2'd1,
        ST_BADREQ = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN,
        S_PUT_RD,
        S_PUT,
        S_RES_RD,
        S_RES,
        S_DONE
    } t_state;
endpackage

/* rtl/bffa_map.sv */
// ----------------------------------------------------------------------------
// Block allocator use map
// Word-wide memory of use bits, one read and one write port.
// ----------------------------------------------------------------------------
module bffa_map
    import bffa_pkg::*;
#(
    parameter int WORDS = 128,
    parameter int AW    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);
    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/bffa_ctrl.sv */
// ----------------------------------------------------------------------------
// Block allocator sequencer
// Scans the map one bit per step and fills or marks it one word per step.
// ----------------------------------------------------------------------------
module bffa_ctrl
    import bffa_pkg::*;
#(
    parameter int MAP_BLOCKS = MAP_BLOCKS_DEF,
    parameter int AW         = 7,
    parameter int BW         = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CNT_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [START_W-1:0]   i_start_block,
    input  logic [CNT_W-1:0]     i_block_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [START_W-1:0]   o_alloc_start,
    output logic [CNT_W-1:0]     o_used_blocks,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [WORD_BITS-1:0] o_wdata,
    output logic [AW-1:0]        o_raddr,
    input  logic [WORD_BITS-1:0] i_rdata
);
    localparam int WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int CW    = ((BW > CNT_W) ? BW : CNT_W) + 1;
    localparam logic [CW-1:0] MAPB = CW'(MAP_BLOCKS);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_total;
    logic [CW-1:0]     r_used, n_used;
    logic [1:0]        r_cmd;
    logic [CW-1:0]     r_start, n_start;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_b, n_b;
    logic [CW-1:0]     r_run, n_run;
    logic [CW-1:0]     r_end;
    logic [CW-1:0]     r_chg, n_chg;
    logic [1:0]        r_status, n_status;
    logic [START_W-1:0] r_found, n_found;
    logic              r_oval, n_oval;
    logic [AW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     act_total, lim, free_n, tot_b;
    logic [WORD_BITS-1:0] n_word;
    logic [4:0]        bpos;

    assign act_total = (CW'(r_total) > MAPB) ? MAPB : CW'(r_total);
    assign free_n    = (r_used >= act_total) ? '0 : act_total - r_used;
    assign bpos      = r_b[4:0];
    assign tot_b     = r_start + r_cnt;

    // Scans one bit per step; fills and marks one map word per step.
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_start  = r_start;
        n_b      = r_b;
        n_run    = r_run;
        n_chg    = r_chg;
        n_status = r_status;
        n_found  = r_found;
        n_oval   = r_oval;
        n_fill   = r_fill;
        n_word   = i_rdata;
        lim      = '0;
        o_we     = 1'b0;
        o_waddr  = r_b[AW+4:5];
        o_wdata  = i_rdata;
        o_raddr  = r_b[AW+4:5];
        if (r_oval && !i_out_stall) begin
            n_oval = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                // fill every map word with ones, one word a cycle
                o_we    = 1'b1;
                o_waddr = r_fill;
                o_wdata = '1;
                n_fill  = r_fill + 1'b1;
                if (r_fill == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && !r_oval) begin
                    n_state  = S_CHECK;
                    n_start  = CW'(i_start_block);
                    n_status = ST_OK;
                    n_found  = '0;
                end
            end
            S_CHECK: begin
                n_run = '0;
                n_chg = '0;
                if (r_cnt == '0) begin
                    n_status = ST_BADREQ;
                    n_state  = S_DONE;
                end else if (r_cmd == CMD_ALLOC) begin
                    if (r_cnt > free_n || act_total == '0) begin
                        n_status = ST_NOSPC;
                        n_state  = S_DONE;
                    end else begin
                        n_b     = '0;
                        n_state = S_SCAN_RD;
                    end
                end else if (tot_b > act_total) begin
                    n_status = ST_BADREQ;
                    n_state  = S_DONE;
                end else begin
                    n_b     = r_start;
                    n_state = S_PUT_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                lim   = i_rdata[bpos] ? '0 : r_run + 1'b1;
                n_run = lim;
                if (lim == r_cnt) begin
                    n_start = r_b + 1'b1 - r_cnt;
                    n_found = START_W'(r_b + 1'b1 - r_cnt);
                    n_b     = r_b + 1'b1 - r_cnt;
                    n_state = S_PUT_RD;
                end else if (r_b + 1'b1 >= act_total) begin
                    n_status = ST_NOSPC;
                    n_state  = S_DONE;
                end else begin
                    n_b = r_b + 1'b1;
                    if (bpos == 5'd31) begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_PUT_RD: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                // set or clear bits of this word until range end or word end
                n_word = i_rdata;
                for (int k = 0; k < WORD_BITS; k++) begin
                    if ({r_b[CW-1:5], 5'(k)} >= r_b &&
                        {r_b[CW-1:5], 5'(k)} < r_end) begin
                        n_word[k] = (r_cmd == CMD_ALLOC || r_cmd == CMD_MARK_USED);
                    end
                end
                o_we    = 1'b1;
                o_wdata = n_word;
                n_chg   = r_chg + CW'($countones(n_word ^ i_rdata));
                if ({r_b[CW-1:5], 5'd0} + CW'(WORD_BITS) >= r_end) begin
                    if (r_cmd == CMD_ALLOC || r_cmd == CMD_MARK_USED) begin
                        lim = r_used + n_chg;
                        n_used = (lim > CW'(COUNT_MAX)) ? CW'(COUNT_MAX) : lim;
                    end else begin
                        n_used = (n_chg > r_used) ? '0 : r_used - n_chg;
                    end
                    if (r_cmd == CMD_MARK_FREE) begin
                        n_b     = '0;
                        n_state = S_RES_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_b     = {r_b[CW-1:5] + 1'b1, 5'd0};
                    n_state = S_PUT_RD;
                end
            end
            S_RES_RD: begin
                n_state = S_RES;
            end
            S_RES: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = i_rdata | WORD_BITS'(1);
                if (!i_rdata[0]) begin
                    n_used = (r_used + 1'b1 > CW'(COUNT_MAX)) ? CW'(COUNT_MAX)
                                                               : r_used + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_oval || !i_out_stall) begin
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_fill  <= '0;
            r_total <= TOTAL_RESET;
            r_used  <= (CW'(TOTAL_RESET) > MAPB) ? MAPB : CW'(TOTAL_RESET);
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_used  <= n_used;
            r_oval  <= n_oval;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid && !r_oval) begin
            r_cmd <= i_command;
            r_cnt <= CW'(i_block_count);
        end
        r_start  <= n_start;
        r_b      <= n_b;
        r_run    <= n_run;
        r_chg    <= n_chg;
        r_status <= n_status;
        r_found  <= n_found;
        r_end    <= n_start + r_cnt;
    end

    assign o_in_stall    = (r_state != S_IDLE) || r_oval;
    assign o_out_valid   = r_oval;
    assign o_status      = r_status;
    assign o_alloc_start = r_found;
    assign o_used_blocks = r_used[CNT_W-1:0];
endmodule

/* rtl/bitmap_first_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator
// Use map of one bit per block with a first-fit search for free runs.
// ----------------------------------------------------------------------------
// A request beat carries a command, a start block and a count; one result beat
// answers it. The map sits in a 32-bit-wide memory with a registered read.
// After reset a fill pass writes ones to every map word, one word per cycle,
// and the input stalls until it ends. A zero count, an out-of-bounds range or
// an alloc that the used count already rules out is answered from the check
// state; a range command reads and writes each map word it touches (mark-free
// then also sets the block 0 reservation). Alloc scans one block per cycle
// from block 0, with a read state before each map word, and answers with the
// first free run of the requested length, or with no space once it passes the
// last active block. The input stalls from acceptance until the cycle after
// the result beat is taken.
module bitmap_first_fit_block_allocator_top
    import bffa_pkg::*;
#(
    parameter int MAP_BLOCKS = MAP_BLOCKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [START_W-1:0] i_start_block,
    input  logic [CNT_W-1:0]   i_block_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [START_W-1:0] o_alloc_start,
    output logic [CNT_W-1:0]   o_used_blocks
);
    localparam int WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = AW + 5;

    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [WORD_BITS-1:0] w_wdata, w_rdata;

    bffa_map #(.WORDS(WORDS), .AW(AW)) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    bffa_ctrl #(.MAP_BLOCKS(MAP_BLOCKS), .AW(AW), .BW(BW)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_start_block(i_start_block),
        .i_block_count(i_block_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_alloc_start(o_alloc_start),
        .o_used_blocks(o_used_blocks),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata)
    );
endmodule

/* rtl/bffa_checker.sv */
// ----------------------------------------------------------------------------
// Block allocator port checker
// Watches the top level's ports for handshake and result rules.
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_block_allocator_top_macros.svh"
module bffa_checker
    import bffa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic [START_W-1:0] o_alloc_start
);
    // a waiting result blocks new requests
    `BFA_ASSERT_IMPL(a_hold_in, i_clk, i_rst_n, o_out_valid, o_in_stall)
    // result beat holds while stalled
    `BFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status))
    // start is zero unless ok
    `BFA_ASSERT_IMPL(a_start_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_alloc_start == '0)
    // accepted request cannot answer next cycle
    `BFA_ASSERT_NEXT(a_no_fast, i_clk, i_rst_n, i_in_valid && !o_in_stall, !o_out_valid)
endmodule

bind bitmap_first_fit_block_allocator_top bffa_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_alloc_start(o_alloc_start)
);
